[hdl/gha_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the generational handle slot allocator.
package gha_pkg;

    localparam int SLOTS_PER_POOL = 256;
    localparam int POOL_COUNT     = 16;
    localparam int SALT_BITS      = 16;
    localparam int HANDLE_W       = 28;

    localparam int SB        = $clog2(SLOTS_PER_POOL);
    localparam int PB        = $clog2(POOL_COUNT);
    localparam int POOL_W    = (PB > 0) ? PB : 1;
    localparam int HEAD_W    = SB + 1;
    localparam int OPEN_W    = $clog2(POOL_COUNT + 1);
    localparam int ADDR_W    = SB + PB;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int EXT_W     = HANDLE_W + SALT_BITS + SB + PB;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] FN_ALLOC  = 2'd0;
    localparam logic [1:0] FN_FREE   = 2'd1;
    localparam logic [1:0] FN_LOOKUP = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_POOL = 2'd2;
    localparam logic [1:0] ST_STALE   = 2'd3;

    typedef struct packed {
        logic [1:0]          func;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic                ok;
        logic [HANDLE_W-1:0] out_handle;
        logic [1:0]          status;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_LOOKUP,
        OP_NOP
    } op_kind_t;

    // A classified request as it travels from the front end to the back end.
    typedef struct packed {
        op_kind_t             kind;
        logic [SB-1:0]        slot;
        logic [POOL_W-1:0]    pool;
        logic [SALT_BITS-1:0] salt;
        logic                 pool_range_bad;
        logic                 slot_range_bad;
        logic [HANDLE_W-1:0]  handle;
    } op_t;

    typedef struct packed {
        logic [HEAD_W-1:0]    next;
        logic [SALT_BITS-1:0] salt;
        logic                 live;
    } slot_word_t;

    typedef enum logic {
        BK_ISSUE,
        BK_EXEC
    } back_state_t;

    function automatic logic [HANDLE_W-1:0] pack_handle(
        input logic [SB-1:0]        slot,
        input logic [POOL_W-1:0]    pool,
        input logic [SALT_BITS-1:0] salt
    );
        logic [EXT_W-1:0] full;
        full = EXT_W'(slot) | (EXT_W'(pool) << SB) | (EXT_W'(salt) << (SB + PB));
        return full[HANDLE_W-1:0];
    endfunction

endpackage

[hdl/gha_front.sv]
`timescale 1ns / 1ps
// Front end: accepts requests, decodes the operation and splits the handle.
module gha_front (
    input  logic          req_valid,
    output logic          req_ready,
    input  gha_pkg::req_t req,
    input  logic          q_full,
    output logic          q_push,
    output gha_pkg::op_t  q_op
);
    import gha_pkg::*;

    logic [EXT_W-1:0] ext;

    assign req_ready = !q_full;
    assign q_push    = req_valid && !q_full;

    always_comb
    begin
        // Salt bits beyond the handle width read as zero.
        ext       = EXT_W'(req.handle);
        q_op      = '0;
        q_op.handle = req.handle;
        q_op.slot = ext[SB-1:0];
        if (PB > 0)
        begin
            q_op.pool = ext[SB +: POOL_W];
        end
        q_op.salt = ext[SB + PB +: SALT_BITS];
        q_op.pool_range_bad = {1'b0, q_op.pool} >= (POOL_W + 1)'(POOL_COUNT);
        q_op.slot_range_bad = {1'b0, q_op.slot} >= (SB + 1)'(SLOTS_PER_POOL);
        unique case (req.func)
            FN_ALLOC:  q_op.kind = OP_ALLOC;
            FN_FREE:   q_op.kind = OP_FREE;
            FN_LOOKUP: q_op.kind = OP_LOOKUP;
            default:   q_op.kind = OP_NOP;
        endcase
    end

endmodule

[hdl/gha_queue.sv]
`timescale 1ns / 1ps
// Short queue of classified requests between the front end and the back end.
module gha_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  gha_pkg::op_t push_op,
    output logic         full,
    output logic         valid,
    output gha_pkg::op_t head,
    input  logic         pop
);
    import gha_pkg::*;

    op_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == QCNT_W'(QDEPTH);
    assign valid = count_reg != '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[hdl/gha_back.sv]
`timescale 1ns / 1ps
// Back end: pool search, slot memory read-modify-write and the response register.
module gha_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  gha_pkg::op_t  q_op,
    output logic          q_pop,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output gha_pkg::rsp_t rsp
);
    import gha_pkg::*;

    back_state_t       state_reg, state_next;
    logic [OPEN_W-1:0] pools_open_reg, pools_open_next;
    logic [HEAD_W-1:0] free_head_reg [POOL_COUNT];
    logic [HEAD_W-1:0] fresh_mark_reg [POOL_COUNT];

    slot_word_t        slot_mem [MEM_DEPTH];
    slot_word_t        rd_word_reg;

    op_t               op_reg;
    logic [POOL_W-1:0] pool_reg;
    logic [SB-1:0]     slot_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [HEAD_W-1:0] head_reg;
    logic              fresh_reg;
    logic              open_reg;
    logic              alloc_ok_reg;
    logic              pool_bad_reg;

    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              cand_found;
    logic [POOL_W-1:0] cand_pool;
    logic              can_open;
    logic [POOL_W-1:0] sel_pool;
    logic [SB-1:0]     sel_slot;
    logic [ADDR_W-1:0] sel_addr;
    logic              sel_fresh;
    logic              sel_pool_bad;

    logic              commit;
    slot_word_t        eff;
    logic              mem_we;
    slot_word_t        mem_wdata;
    logic              head_we;
    logic [HEAD_W-1:0] head_wdata;
    logic              mark_we;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Pool search and address selection for the request at the queue head.
    always_comb
    begin
        cand_found = 1'b0;
        cand_pool  = '0;
        for (int i = POOL_COUNT - 1; i >= 0; i--)
        begin
            if (OPEN_W'(i) < pools_open_reg && free_head_reg[i] < HEAD_W'(SLOTS_PER_POOL))
            begin
                cand_found = 1'b1;
                cand_pool  = POOL_W'(i);
            end
        end
        can_open = pools_open_reg < OPEN_W'(POOL_COUNT);
        if (q_op.kind == OP_ALLOC)
        begin
            if (cand_found)
            begin
                sel_pool = cand_pool;
            end
            else if (can_open)
            begin
                sel_pool = POOL_W'(pools_open_reg);
            end
            else
            begin
                sel_pool = '0;
            end
            sel_slot = free_head_reg[sel_pool][SB-1:0];
        end
        else
        begin
            sel_pool = q_op.pool_range_bad ? '0 : q_op.pool;
            sel_slot = q_op.slot;
        end
        sel_addr = ADDR_W'(ADDR_W'(sel_pool) << SB) | ADDR_W'(sel_slot);
        // Slots from the fill mark up were never handed out, so their words are unwritten.
        sel_fresh    = {1'b0, sel_slot} >= fresh_mark_reg[sel_pool];
        sel_pool_bad = q_op.pool_range_bad || (OPEN_W'(q_op.pool) >= pools_open_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            BK_ISSUE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    commit     = 1'b1;
                    state_next = BK_ISSUE;
                end
            end
            default: state_next = BK_ISSUE;
        endcase
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Result and state updates for the request held in the execute stage.
    always_comb
    begin
        if (fresh_reg)
        begin
            eff.next = HEAD_W'(slot_reg) + HEAD_W'(1);
            eff.salt = '0;
            eff.live = 1'b0;
        end
        else
        begin
            eff = rd_word_reg;
        end
        rsp_next.ok         = 1'b0;
        rsp_next.out_handle = op_reg.handle;
        rsp_next.status     = ST_DONE;
        mem_we          = 1'b0;
        mem_wdata       = eff;
        head_we         = 1'b0;
        head_wdata      = eff.next;
        mark_we         = 1'b0;
        pools_open_next = pools_open_reg;
        unique case (op_reg.kind) inside
            OP_ALLOC:
            begin
                if (alloc_ok_reg)
                begin
                    rsp_next.ok         = 1'b1;
                    rsp_next.out_handle = pack_handle(slot_reg, pool_reg, eff.salt);
                    mem_we         = 1'b1;
                    mem_wdata.live = 1'b1;
                    head_we        = 1'b1;
                    mark_we        = fresh_reg;
                    if (open_reg)
                    begin
                        pools_open_next = pools_open_reg + OPEN_W'(1);
                    end
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            OP_FREE, OP_LOOKUP:
            begin
                if (pool_bad_reg)
                begin
                    rsp_next.status = ST_NO_POOL;
                end
                else if (op_reg.slot_range_bad || !eff.live || eff.salt != op_reg.salt)
                begin
                    rsp_next.status = ST_STALE;
                end
                else
                begin
                    rsp_next.ok = 1'b1;
                    if (op_reg.kind == OP_FREE)
                    begin
                        mem_we         = 1'b1;
                        mem_wdata.next = head_reg;
                        mem_wdata.salt = eff.salt + SALT_BITS'(1);
                        mem_wdata.live = 1'b0;
                        head_we        = 1'b1;
                        head_wdata     = HEAD_W'(slot_reg);
                    end
                end
            end
            default: ;
        endcase
        if (!commit)
        begin
            mem_we          = 1'b0;
            head_we         = 1'b0;
            mark_we         = 1'b0;
            pools_open_next = pools_open_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_ISSUE;
            pools_open_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            for (int i = 0; i < POOL_COUNT; i++)
            begin
                free_head_reg[i]  <= '0;
                fresh_mark_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pools_open_reg <= pools_open_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (head_we)
            begin
                free_head_reg[pool_reg] <= head_wdata;
            end
            if (mark_we)
            begin
                fresh_mark_reg[pool_reg] <= HEAD_W'(slot_reg) + HEAD_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg       <= q_op;
            pool_reg     <= sel_pool;
            slot_reg     <= sel_slot;
            addr_reg     <= sel_addr;
            head_reg     <= free_head_reg[sel_pool];
            fresh_reg    <= sel_fresh;
            open_reg     <= !cand_found && can_open;
            alloc_ok_reg <= cand_found || can_open;
            pool_bad_reg <= sel_pool_bad;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[addr_reg] <= mem_wdata;
        end
        if (q_pop)
        begin
            rd_word_reg <= slot_mem[sel_addr];
        end
    end

endmodule

[hdl/generational_handle_slot_allocator.sv]
`timescale 1ns / 1ps
// Top level of the generational handle slot allocator.
// Each request allocates, frees or looks up a handle packed as slot index (low 8 bits),
// pool index (next 4 bits) and generation salt (high 16 bits), and yields one response.
// In the back end the issue state searches the pools and reads the slot memory, and the
// execute state checks and writes it back. A new request is taken only once the last one
// has finished, owing to that single-port read-then-write of the slot memory. A
// two-entry queue lets new requests be taken while a response waits. Slots never handed
// out are tracked by a per-pool fill mark, so no clearing pass follows reset.
module generational_handle_slot_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  gha_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output gha_pkg::rsp_t rsp
);
    import gha_pkg::*;

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    op_t  push_op;
    op_t  head_op;

    gha_front u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (push_op)
    );

    gha_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .valid   (q_valid),
        .head    (head_op),
        .pop     (q_pop)
    );

    gha_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (head_op),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[hdl/gha_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the allocator and their binding to the top level.
module gha_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input gha_pkg::rsp_t rsp
);
    import gha_pkg::*;

    // A stalled response holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

    // A successful operation always reports done.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.ok |-> rsp.status == ST_DONE)
    else $error("ok response with a failure status");

    // A failed free or lookup never reports an allocation failure, and a failed allocation
    // reports nothing but a full allocator; here a full or missing pool is never marked ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_NO_POOL) |-> !rsp.ok)
    else $error("failure status marked ok");

    // Nothing is offered right after reset is released.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
    else $error("response present out of reset");

endmodule

bind generational_handle_slot_allocator gha_checker u_gha_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the generational handle slot allocator with a scoreboard class.
module testbench;
    import gha_pkg::*;

    localparam logic [1:0]  FN_UNUSED = 2'd3;
    localparam logic [63:0] GEN_MASK  = (64'd1 << SALT_BITS) - 64'd1;
    localparam logic [63:0] SLOT_MASK = (64'd1 << SB) - 64'd1;
    localparam logic [63:0] POOL_MASK = (64'd1 << PB) - 64'd1;
    localparam int          RETIRED_KEEP = 256;

    class handle_scoreboard;
        int unsigned pools_open;
        int unsigned free_head[POOL_COUNT];
        int unsigned next_free[POOL_COUNT * SLOTS_PER_POOL];
        int unsigned slot_salt[POOL_COUNT * SLOTS_PER_POOL];
        bit          slot_live[POOL_COUNT * SLOTS_PER_POOL];
        rsp_t                pending_rsp[$];
        logic [HANDLE_W-1:0] live_handles[$];
        logic [HANDLE_W-1:0] retired_handles[$];
        int failures;

        function new();
            int unsigned p;
            int unsigned s;
            pools_open = 0;
            failures = 0;
            for (p = 0; p < POOL_COUNT; p++)
            begin
                free_head[p] = 0;
                for (s = 0; s < SLOTS_PER_POOL; s++)
                begin
                    next_free[p * SLOTS_PER_POOL + s] = s + 1;
                    slot_salt[p * SLOTS_PER_POOL + s] = 0;
                    slot_live[p * SLOTS_PER_POOL + s] = 1'b0;
                end
            end
        endfunction

        function int outstanding();
            return pending_rsp.size();
        endfunction

        // Applies one accepted request to the predicted pool state and queues its response.
        function void note_request(req_t r);
            rsp_t        want;
            logic [63:0] h;
            logic [63:0] built;
            int unsigned slot;
            int unsigned pool;
            int unsigned salt;
            int unsigned idx;
            int unsigned pick;
            int unsigned p;
            int          k;
            bit          found;
            h = 64'(r.handle);
            want.ok = 1'b0;
            want.out_handle = r.handle;
            want.status = ST_DONE;
            if (r.func == FN_ALLOC)
            begin
                pick = POOL_COUNT;
                for (p = 0; p < pools_open && pick == POOL_COUNT; p++)
                    if (free_head[p] < SLOTS_PER_POOL)
                        pick = p;
                if (pick == POOL_COUNT && pools_open < POOL_COUNT)
                begin
                    pick = pools_open;
                    pools_open++;
                end
                if (pick < POOL_COUNT && free_head[pick] < SLOTS_PER_POOL)
                begin
                    slot = free_head[pick];
                    idx = pick * SLOTS_PER_POOL + slot;
                    free_head[pick] = next_free[idx];
                    slot_live[idx] = 1'b1;
                    built = 64'(slot) | (64'(pick) << SB) |
                            ((64'(slot_salt[idx]) & GEN_MASK) << (SB + PB));
                    want.ok = 1'b1;
                    want.out_handle = built[HANDLE_W-1:0];
                    live_handles = {live_handles, want.out_handle};
                end
                else
                    want.status = ST_FULL;
            end
            else if (r.func == FN_FREE || r.func == FN_LOOKUP)
            begin
                slot = int'(h & SLOT_MASK);
                pool = int'((h >> SB) & POOL_MASK);
                salt = int'((h >> (SB + PB)) & GEN_MASK);
                if (pool >= pools_open || pool >= POOL_COUNT)
                    want.status = ST_NO_POOL;
                else if (slot >= SLOTS_PER_POOL)
                    want.status = ST_STALE;
                else
                begin
                    idx = pool * SLOTS_PER_POOL + slot;
                    // A slot on the free list or with another generation is never current.
                    if (!slot_live[idx] || slot_salt[idx] != salt)
                        want.status = ST_STALE;
                    else
                    begin
                        want.ok = 1'b1;
                        if (r.func == FN_FREE)
                        begin
                            next_free[idx] = free_head[pool];
                            free_head[pool] = slot;
                            slot_salt[idx] = int'((64'(slot_salt[idx]) + 64'd1) & GEN_MASK);
                            slot_live[idx] = 1'b0;
                            found = 1'b0;
                            for (k = 0; k < live_handles.size() && !found; k++)
                            begin
                                if (live_handles[k] == r.handle)
                                begin
                                    live_handles.delete(k);
                                    found = 1'b1;
                                end
                            end
                            retired_handles = {retired_handles, r.handle};
                            if (retired_handles.size() > RETIRED_KEEP)
                                void'(retired_handles.pop_front());
                        end
                    end
                end
            end
            pending_rsp = {pending_rsp, want};
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display({"ERROR: response ok=%0b handle=%h status=%0d",
                              " with no request pending"},
                             got.ok, got.out_handle, got.status);
                return;
            end
            want = pending_rsp.pop_front();
            if (got.ok !== want.ok || got.out_handle !== want.out_handle ||
                got.status !== want.status)
            begin
                failures++;
                if (failures <= 10)
                    $display({"ERROR: expected ok=%0b handle=%h status=%0d,",
                              " got ok=%0b handle=%h status=%0d"},
                             want.ok, want.out_handle, want.status,
                             got.ok, got.out_handle, got.status);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    handle_scoreboard sb;
    int send_idle;
    int recv_stall;

    generational_handle_slot_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [HANDLE_W-1:0] make_handle(int unsigned slot, int unsigned pool,
                                                        int unsigned salt);
        logic [63:0] w;
        w = (64'(slot) & SLOT_MASK) | ((64'(pool) & POOL_MASK) << SB) |
            ((64'(salt) & GEN_MASK) << (SB + PB));
        return w[HANDLE_W-1:0];
    endfunction

    task automatic send_req(input logic [1:0] func, input logic [HANDLE_W-1:0] handle);
        req_t r;
        r.func = func;
        r.handle = handle;
        if (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Mostly well-formed traffic on live handles, plus stale, random and unused requests.
    task automatic pick_random(output logic [1:0] func, output logic [HANDLE_W-1:0] handle);
        int          roll;
        int          k;
        logic [63:0] flip;
        roll = $urandom_range(99);
        handle = HANDLE_W'($urandom);
        func = FN_ALLOC;
        if (roll < 30)
            func = FN_ALLOC;
        else if (roll < 75 && sb.live_handles.size() > 0)
        begin
            k = $urandom_range(sb.live_handles.size() - 1);
            handle = sb.live_handles[k];
            func = (roll < 55) ? FN_FREE : FN_LOOKUP;
        end
        else if (roll < 83 && sb.retired_handles.size() > 0)
        begin
            k = $urandom_range(sb.retired_handles.size() - 1);
            handle = sb.retired_handles[k];
            func = $urandom_range(1) ? FN_FREE : FN_LOOKUP;
        end
        else if (roll < 88 && sb.live_handles.size() > 0)
        begin
            k = $urandom_range(sb.live_handles.size() - 1);
            do
                flip = 64'($urandom) & GEN_MASK;
            while (flip == 64'd0);
            handle = sb.live_handles[k] ^ HANDLE_W'(flip << (SB + PB));
            func = $urandom_range(1) ? FN_FREE : FN_LOOKUP;
        end
        else if (roll < 95)
            func = $urandom_range(1) ? FN_FREE : FN_LOOKUP;
        else
            func = FN_UNUSED;
    endtask

    task automatic run_random(input int count, input int s_idle, input int r_stall);
        logic [1:0]          func;
        logic [HANDLE_W-1:0] handle;
        int                  n;
        send_idle = s_idle;
        recv_stall = r_stall;
        for (n = 0; n < count; n++)
        begin
            pick_random(func, handle);
            send_req(func, handle);
            if ($urandom_range(199) == 0)
                drain_responses();
        end
        drain_responses();
    endtask

    initial
    begin
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                sb.check_response(rsp);
            rsp_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial
    begin
        int n;
        sb = new();
        send_idle = 0;
        recv_stall = 0;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests against an empty allocator, then the basic life of two slots.
        send_req(FN_LOOKUP, '0);
        send_req(FN_FREE, '1);
        send_req(FN_UNUSED, '1);
        send_req(FN_UNUSED, '0);
        send_req(FN_ALLOC, '1);
        send_req(FN_ALLOC, '0);
        send_req(FN_LOOKUP, make_handle(0, 0, 0));
        send_req(FN_LOOKUP, make_handle(0, 0, 1));
        send_req(FN_LOOKUP, make_handle(2, 0, 0));
        send_req(FN_FREE, make_handle(2, 0, 0));
        send_req(FN_FREE, make_handle(0, 0, 0));
        send_req(FN_FREE, make_handle(0, 0, 0));
        send_req(FN_LOOKUP, make_handle(0, 0, 0));
        send_req(FN_ALLOC, '0);
        send_req(FN_LOOKUP, make_handle(0, 0, 1));
        send_req(FN_LOOKUP, make_handle(1, 1, 0));
        send_req(FN_FREE, make_handle(SLOTS_PER_POOL - 1, POOL_COUNT - 1, 0));
        send_req(FN_FREE, make_handle(1, 0, 32'(GEN_MASK)));
        send_req(FN_FREE, make_handle(1, 0, 0));
        send_req(FN_LOOKUP, make_handle(1, 0, 0));
        send_req(FN_ALLOC, '1);
        send_req(FN_LOOKUP, make_handle(1, 0, 1));
        send_req(FN_UNUSED, make_handle(1, 0, 1));
        drain_responses();

        // Cycle one slot through several generations.
        for (n = 0; n < 20; n++)
        begin
            send_req(FN_ALLOC, HANDLE_W'($urandom));
            send_req(FN_FREE, sb.live_handles[sb.live_handles.size() - 1]);
        end
        send_req(FN_ALLOC, HANDLE_W'($urandom));
        send_req(FN_LOOKUP, sb.live_handles[sb.live_handles.size() - 1]);
        drain_responses();

        run_random(110, 0, 0);
        run_random(110, 45, 0);
        run_random(110, 0, 45);
        run_random(110, 36, 36);

        recv_stall = 0;
        drain_responses();
        if (sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
hdl/gha_pkg.sv
hdl/gha_front.sv
hdl/gha_queue.sv
hdl/gha_back.sv
hdl/generational_handle_slot_allocator.sv
hdl/gha_checker.sv
tb/testbench.sv
